### hw/rtl/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants for the root counter timer channel.
// ----------------------------------------------------------------------------
package rct_pkg;

	localparam logic [15:0] MAXV      = 16'hffff;
	localparam logic [16:0] MAXV_W    = 17'h0ffff;
	localparam logic [16:0] MAXV_X2   = 17'h1fffe;
	localparam int          DIV_STEPS = 17;

	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_BLANK = 3'd1;
	localparam logic [2:0] KIND_READ  = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_APPLY = 3'd4;

	localparam logic [2:0] REG_TARGET     = 3'd0;
	localparam logic [2:0] REG_SYNC_EN    = 3'd1;
	localparam logic [2:0] REG_SYNC_MODE  = 3'd2;
	localparam logic [2:0] REG_RST_TGT    = 3'd3;
	localparam logic [2:0] REG_IRQ_TGT    = 3'd4;
	localparam logic [2:0] REG_IRQ_MAX    = 3'd5;
	localparam logic [2:0] REG_IRQ_REPEAT = 3'd6;
	localparam logic [2:0] REG_IRQ_TOGGLE = 3'd7;

	localparam logic [1:0] SYNC_MODE0 = 2'd0;
	localparam logic [1:0] SYNC_MODE1 = 2'd1;
	localparam logic [1:0] SYNC_MODE2 = 2'd2;
	localparam logic [1:0] SYNC_MODE3 = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ARITH,
		ST_DIV,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### hw/rtl/root_counter_timer_channel_core.sv
// ----------------------------------------------------------------------------
// root_counter_timer_channel_core
// One 16-bit root counter channel with target compare, blank sync and
// pulse or toggle interrupt generation.
//
//   channel  handshake              word
//   in       in_valid / in_ready    mode, ticks, blank, new_counter
//   out      out_valid / out_ready  irq_pulse, count_value, flags
//   cfg      APB write/read         8 registers at 4*i
//
// An item passes accept, add and commit, plus a divide step when an unpaused
// tick hits a nonzero target with reset_at_target set: the wrap modulo target
// runs 17 steps via one shared subtractor. in_ready is high only when idle.
// The result sits in an output register; commit waits while it is held.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module root_counter_timer_channel_core #(
	parameter bit IS_THIRD_CHANNEL = 1'b0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [15:0] ticks,
	input  logic        blank,
	input  logic [15:0] new_counter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        irq_pulse,
	output logic [15:0] count_value,
	output logic        target_seen,
	output logic        max_seen,
	output logic        no_request,
	output logic        is_paused
);
	import rct_pkg::*;

	function automatic logic upd_paused(input logic live, input logic blk,
			input logic cur, input logic [1:0] smode);
		logic res;
		if (!live) begin
			res = 1'b0;
		end else if (!IS_THIRD_CHANNEL) begin
			if (smode == SYNC_MODE0) res = blk;
			else if (smode == SYNC_MODE1) res = 1'b0;
			else res = !blk;
		end else begin
			res = cur && (smode == SYNC_MODE0 || smode == SYNC_MODE3);
		end
		return res;
	endfunction

	// configuration
	logic [15:0] target_q;
	logic        sync_enable_q;
	logic [1:0]  sync_mode_q;
	logic        reset_at_target_q;
	logic        irq_on_target_q;
	logic        irq_on_max_q;
	logic        irq_repeat_q;
	logic        irq_toggle_q;
	logic        cfg_wr;

	// channel state
	logic [15:0] counter_q;
	logic        irq_latched_q;
	logic        target_flag_q;
	logic        max_flag_q;
	logic        request_flag_q;
	logic        paused_q;
	logic        in_blank_q;
	logic        sync_live_q;

	// sequencer
	state_t      state_q, state_d;
	logic [2:0]  mode_q;
	logic [15:0] ticks_q;
	logic        blank_q;
	logic [15:0] new_counter_q;
	logic [16:0] sum_q;
	logic        tgt_hit_q;
	logic        div_used_q;
	logic        out_valid_q;
	logic        slot_free;
	logic        accept;
	logic        commit;
	logic        div_start;
	div_stat_t   div_stat;
	logic [15:0] div_rem;

	// arithmetic stage
	logic [16:0] sum_a;
	logic        tgt_hit_a;
	logic        need_div;

	// commit
	logic [16:0] fin;
	logic        max_hit;
	logic [16:0] fin_wrap;
	logic        irq;
	logic [15:0] n_counter;
	logic        n_latched;
	logic        n_tflag;
	logic        n_mflag;
	logic        n_req;
	logic        n_paused;
	logic        n_in_blank;
	logic        n_sync_live;
	logic        n_pulse;
	logic        n_tflag_kept;
	logic        n_mflag_kept;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q          <= '0;
			sync_enable_q     <= 1'b0;
			sync_mode_q       <= SYNC_MODE0;
			reset_at_target_q <= 1'b0;
			irq_on_target_q   <= 1'b0;
			irq_on_max_q      <= 1'b0;
			irq_repeat_q      <= 1'b0;
			irq_toggle_q      <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_TARGET:     target_q          <= pwdata[15:0];
				REG_SYNC_EN:    sync_enable_q     <= pwdata[0];
				REG_SYNC_MODE:  sync_mode_q       <= pwdata[1:0];
				REG_RST_TGT:    reset_at_target_q <= pwdata[0];
				REG_IRQ_TGT:    irq_on_target_q   <= pwdata[0];
				REG_IRQ_MAX:    irq_on_max_q      <= pwdata[0];
				REG_IRQ_REPEAT: irq_repeat_q      <= pwdata[0];
				REG_IRQ_TOGGLE: irq_toggle_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_TARGET:     prdata = 32'(target_q);
			REG_SYNC_EN:    prdata = 32'(sync_enable_q);
			REG_SYNC_MODE:  prdata = 32'(sync_mode_q);
			REG_RST_TGT:    prdata = 32'(reset_at_target_q);
			REG_IRQ_TGT:    prdata = 32'(irq_on_target_q);
			REG_IRQ_MAX:    prdata = 32'(irq_on_max_q);
			REG_IRQ_REPEAT: prdata = 32'(irq_repeat_q);
			REG_IRQ_TOGGLE: prdata = 32'(irq_toggle_q);
			default:        prdata = '0;
		endcase
	end

	assign sum_a     = {1'b0, counter_q} + {1'b0, ticks_q};
	assign tgt_hit_a = (sum_a >= {1'b0, target_q}) &&
		((counter_q < target_q) || (target_q == '0));
	assign need_div  = (mode_q == KIND_TICK) && !paused_q && tgt_hit_a &&
		reset_at_target_q && (target_q != '0);

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_ARITH;
			ST_ARITH:  state_d = need_div ? ST_DIV : ST_COMMIT;
			ST_DIV:    if (div_stat.done) state_d = ST_COMMIT;
			ST_COMMIT: if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_ARITH) && need_div;
		commit    = (state_q == ST_COMMIT) && slot_free;
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q        <= mode;
			ticks_q       <= ticks;
			blank_q       <= blank;
			new_counter_q <= new_counter;
		end
		if (state_q == ST_ARITH) begin
			sum_q      <= sum_a;
			tgt_hit_q  <= tgt_hit_a;
			div_used_q <= need_div;
		end
	end

	rct_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_a),
		.divisor  (target_q),
		.stat     (div_stat),
		.rem      (div_rem)
	);

	assign fin      = div_used_q ? {1'b0, div_rem} : sum_q;
	assign max_hit  = fin >= MAXV_W;
	assign fin_wrap = (fin == MAXV_X2) ? '0 : (max_hit ? fin - MAXV_W : fin);

	always_comb begin
		n_counter   = counter_q;
		n_latched   = irq_latched_q;
		n_tflag     = target_flag_q;
		n_mflag     = max_flag_q;
		n_req       = request_flag_q;
		n_paused    = paused_q;
		n_in_blank  = in_blank_q;
		n_sync_live = sync_live_q;
		n_pulse     = 1'b0;
		irq         = 1'b0;
		case (mode_q)
			KIND_TICK: begin
				if (!paused_q) begin
					if (tgt_hit_q) begin
						n_tflag = 1'b1;
						if (irq_on_target_q) irq = 1'b1;
					end
					if (max_hit) begin
						n_mflag = 1'b1;
						if (irq_on_max_q) irq = 1'b1;
					end
					n_counter = fin_wrap[15:0];
					if (irq) begin
						if (irq_toggle_q) begin
							if (irq_repeat_q || request_flag_q) begin
								n_req = !request_flag_q;
								if (request_flag_q && (!irq_latched_q || irq_repeat_q)) begin
									n_latched = 1'b1;
									n_pulse   = 1'b1;
								end
							end
						end else begin
							n_req = 1'b1;
							if (!irq_latched_q || irq_repeat_q) begin
								n_latched = 1'b1;
								n_pulse   = 1'b1;
							end
						end
					end
					if (IS_THIRD_CHANNEL && n_pulse && sync_live_q &&
							(sync_mode_q == SYNC_MODE0 || sync_mode_q == SYNC_MODE3)) begin
						n_counter = (irq_on_target_q && n_tflag) ? target_q : MAXV;
						n_paused  = 1'b1;
					end
				end
			end
			KIND_BLANK: begin
				if (in_blank_q != blank_q) begin
					n_in_blank = blank_q;
					if (sync_live_q && blank_q) begin
						if (sync_mode_q == SYNC_MODE1 || sync_mode_q == SYNC_MODE2) begin
							n_counter = '0;
						end else if (sync_mode_q == SYNC_MODE3) begin
							n_sync_live = 1'b0;
						end
					end
					n_paused = upd_paused(n_sync_live, n_in_blank, paused_q, sync_mode_q);
				end
			end
			KIND_WRITE: begin
				n_counter = new_counter_q;
			end
			KIND_APPLY: begin
				n_latched   = 1'b0;
				n_counter   = '0;
				n_sync_live = sync_enable_q;
				if (irq_toggle_q) n_req = 1'b1;
				n_paused = upd_paused(n_sync_live, in_blank_q, paused_q, sync_mode_q);
			end
			default: ;
		endcase
		n_tflag_kept = (mode_q == KIND_READ) ? 1'b0 : n_tflag;
		n_mflag_kept = (mode_q == KIND_READ) ? 1'b0 : n_mflag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q      <= '0;
			irq_latched_q  <= 1'b0;
			target_flag_q  <= 1'b0;
			max_flag_q     <= 1'b0;
			request_flag_q <= 1'b1;
			paused_q       <= 1'b0;
			in_blank_q     <= 1'b0;
			sync_live_q    <= 1'b0;
		end else if (commit) begin
			counter_q      <= n_counter;
			irq_latched_q  <= n_latched;
			target_flag_q  <= n_tflag_kept;
			max_flag_q     <= n_mflag_kept;
			request_flag_q <= n_req;
			paused_q       <= n_paused;
			in_blank_q     <= n_in_blank;
			sync_live_q    <= n_sync_live;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			irq_pulse   <= n_pulse;
			count_value <= n_counter;
			target_seen <= n_tflag;
			max_seen    <= n_mflag;
			no_request  <= n_req;
			is_paused   <= n_paused;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/rct_mod_unit.sv
// ----------------------------------------------------------------------------
// rct_mod_unit
// Restoring remainder unit: 17-bit dividend modulo 16-bit divisor,
// one bit per cycle through a single shared subtractor.
// ----------------------------------------------------------------------------
module rct_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [16:0]       dividend,
	input  logic [15:0]       divisor,
	output rct_pkg::div_stat_t stat,
	output logic [15:0]       rem
);
	import rct_pkg::*;

	logic [16:0] dvd_q;
	logic [15:0] dsr_q;
	logic [15:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] shifted;
	logic [17:0] diff;

	assign shifted = {rem_q, dvd_q[16]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[15:0], 1'b0};
			rem_q <= diff[17] ? shifted[15:0] : diff[15:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

### hw/rtl/rct_checker.sv
// ----------------------------------------------------------------------------
// rct_checker
// Port-level checks for the root counter timer channel, bound to the core.
// ----------------------------------------------------------------------------
module rct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        irq_pulse,
	input logic [15:0] count_value,
	input logic        target_seen,
	input logic        max_seen,
	input logic        no_request,
	input logic        is_paused
);

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({irq_pulse, count_value, target_seen, max_seen, no_request, is_paused}))
		else $error("output word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken again before the word was worked");

	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("block went idle without presenting a result");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind root_counter_timer_channel_core rct_checker u_rct_checker (.*);

### test/tb_root_counter_timer_channel_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_root_counter_timer_channel_core
// Self-checking bench for the root counter timer channel. Each word is sent
// on the input channel. A channel model inside the bench predicts the status
// word that comes back, and each returned word is checked against it.
// Directed tests cover counting, sync and interrupt forms. Random phases
// follow, with register settings changed between bursts and, in the first
// two phases, random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_root_counter_timer_channel_core;
	import rct_pkg::*;

	localparam bit THIRD_CHANNEL = 1'b0;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic [15:0] target;
		logic        sync_en;
		logic [1:0]  sync_mode;
		logic        rst_tgt;
		logic        irq_tgt;
		logic        irq_max;
		logic        irq_repeat;
		logic        irq_toggle;
	} chan_cfg_t;

	typedef struct packed {
		logic        irq_pulse;
		logic [15:0] count_value;
		logic        target_seen;
		logic        max_seen;
		logic        no_request;
		logic        is_paused;
	} chan_status_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  mode = KIND_TICK;
	logic [15:0] ticks = '0;
	logic        blank = 1'b0;
	logic [15:0] new_counter = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        irq_pulse;
	logic [15:0] count_value;
	logic        target_seen;
	logic        max_seen;
	logic        no_request;
	logic        is_paused;

	chan_cfg_t    chan_cfg = '0;
	logic [15:0]  chan_counter = '0;
	logic         chan_irq_latched = 1'b0;
	logic         chan_target_flag = 1'b0;
	logic         chan_max_flag = 1'b0;
	logic         chan_request = 1'b1;
	logic         chan_paused = 1'b0;
	logic         chan_in_blank = 1'b0;
	logic         chan_sync_live = 1'b0;

	chan_status_t expected_status_q[$];
	int           tx_idle_pct = 22;
	int           rx_idle_pct = 73;
	int           fail_count = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;

	root_counter_timer_channel_core #(
		.IS_THIRD_CHANNEL(THIRD_CHANNEL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.ticks(ticks),
		.blank(blank),
		.new_counter(new_counter),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.irq_pulse(irq_pulse),
		.count_value(count_value),
		.target_seen(target_seen),
		.max_seen(max_seen),
		.no_request(no_request),
		.is_paused(is_paused)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic signal_irq();
		if (!chan_irq_latched || chan_cfg.irq_repeat) begin
			chan_irq_latched = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void update_pause();
		if (!chan_sync_live) begin
			chan_paused = 1'b0;
		end else if (!THIRD_CHANNEL) begin
			if (chan_cfg.sync_mode == SYNC_MODE0)
				chan_paused = chan_in_blank;
			else if (chan_cfg.sync_mode == SYNC_MODE1)
				chan_paused = 1'b0;
			else
				chan_paused = !chan_in_blank;
		end else begin
			chan_paused = chan_paused &&
				(chan_cfg.sync_mode == SYNC_MODE0 || chan_cfg.sync_mode == SYNC_MODE3);
		end
	endfunction

	function automatic chan_status_t predict_channel_status(logic [2:0] md, logic [15:0] tk,
			logic bl, logic [15:0] nc);
		logic [16:0]  sum;
		logic         hit;
		logic         pulse;
		chan_status_t st;
		pulse = 1'b0;
		case (md)
		KIND_TICK: begin
			if (!chan_paused) begin
				sum = {1'b0, chan_counter} + {1'b0, tk};
				hit = 1'b0;
				if (sum >= {1'b0, chan_cfg.target} &&
						(chan_counter < chan_cfg.target || chan_cfg.target == 16'd0)) begin
					chan_target_flag = 1'b1;
					if (chan_cfg.irq_tgt)
						hit = 1'b1;
					if (chan_cfg.rst_tgt && chan_cfg.target != 16'd0)
						sum = sum % {1'b0, chan_cfg.target};
				end
				if (sum >= MAXV_W) begin
					chan_max_flag = 1'b1;
					if (chan_cfg.irq_max)
						hit = 1'b1;
					sum = sum % MAXV_W;
				end
				chan_counter = sum[15:0];
				if (hit) begin
					if (chan_cfg.irq_toggle) begin
						if (chan_cfg.irq_repeat || chan_request) begin
							chan_request = !chan_request;
							if (!chan_request)
								pulse = signal_irq();
						end
					end else begin
						chan_request = 1'b1;
						pulse = signal_irq();
					end
				end
				if (pulse && THIRD_CHANNEL && chan_sync_live &&
						(chan_cfg.sync_mode == SYNC_MODE0 || chan_cfg.sync_mode == SYNC_MODE3)) begin
					chan_counter = (chan_cfg.irq_tgt && chan_target_flag) ? chan_cfg.target : MAXV;
					chan_paused = 1'b1;
				end
			end
		end
		KIND_BLANK: begin
			if (chan_in_blank != bl) begin
				chan_in_blank = bl;
				if (chan_sync_live && bl) begin
					if (chan_cfg.sync_mode == SYNC_MODE1 || chan_cfg.sync_mode == SYNC_MODE2)
						chan_counter = 16'd0;
					else if (chan_cfg.sync_mode == SYNC_MODE3)
						chan_sync_live = 1'b0;
				end
				update_pause();
			end
		end
		KIND_WRITE: begin
			chan_counter = nc;
		end
		KIND_APPLY: begin
			chan_irq_latched = 1'b0;
			chan_counter = 16'd0;
			chan_sync_live = chan_cfg.sync_en;
			if (chan_cfg.irq_toggle)
				chan_request = 1'b1;
			update_pause();
		end
		default: ;
		endcase
		st.irq_pulse = pulse;
		st.count_value = chan_counter;
		st.target_seen = chan_target_flag;
		st.max_seen = chan_max_flag;
		st.no_request = chan_request;
		st.is_paused = chan_paused;
		if (md == KIND_READ) begin
			chan_target_flag = 1'b0;
			chan_max_flag = 1'b0;
		end
		return st;
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		chan_status_t exp_st;
		chan_status_t got_st;
		if (arst_n && out_valid && out_ready) begin
			got_st = {irq_pulse, count_value, target_seen, max_seen, no_request, is_paused};
			if (expected_status_q.size() == 0) begin
				fail_count++;
				if (mismatch_count < 10)
					$display("unexpected word: count=%h", count_value);
				mismatch_count++;
			end else begin
				exp_st = expected_status_q.pop_front();
				if (got_st != exp_st) begin
					fail_count++;
					if (mismatch_count < 10)
						$display("mismatch: exp pulse=%0d count=%h tgt=%0d max=%0d noreq=%0d pause=%0d, got pulse=%0d count=%h tgt=%0d max=%0d noreq=%0d pause=%0d",
							exp_st.irq_pulse, exp_st.count_value, exp_st.target_seen,
							exp_st.max_seen, exp_st.no_request, exp_st.is_paused,
							got_st.irq_pulse, got_st.count_value, got_st.target_seen,
							got_st.max_seen, got_st.no_request, got_st.is_paused);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_counter_word(input logic [2:0] md, input logic [15:0] tk,
			input logic bl, input logic [15:0] nc);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		ticks <= tk;
		blank <= bl;
		new_counter <= nc;
		do @(posedge clk); while (!in_ready);
		expected_status_q.push_back(predict_channel_status(md, tk, bl, nc));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
		REG_TARGET:     chan_cfg.target = value;
		REG_SYNC_EN:    chan_cfg.sync_en = value[0];
		REG_SYNC_MODE:  chan_cfg.sync_mode = value[1:0];
		REG_RST_TGT:    chan_cfg.rst_tgt = value[0];
		REG_IRQ_TGT:    chan_cfg.irq_tgt = value[0];
		REG_IRQ_MAX:    chan_cfg.irq_max = value[0];
		REG_IRQ_REPEAT: chan_cfg.irq_repeat = value[0];
		REG_IRQ_TOGGLE: chan_cfg.irq_toggle = value[0];
		default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input chan_cfg_t c);
		wait_idle();
		write_reg(REG_TARGET, c.target);
		write_reg(REG_SYNC_EN, {15'd0, c.sync_en});
		write_reg(REG_SYNC_MODE, {14'd0, c.sync_mode});
		write_reg(REG_RST_TGT, {15'd0, c.rst_tgt});
		write_reg(REG_IRQ_TGT, {15'd0, c.irq_tgt});
		write_reg(REG_IRQ_MAX, {15'd0, c.irq_max});
		write_reg(REG_IRQ_REPEAT, {15'd0, c.irq_repeat});
		write_reg(REG_IRQ_TOGGLE, {15'd0, c.irq_toggle});
	endtask

	function automatic chan_cfg_t random_settings(int pick);
		chan_cfg_t c;
		c = '0;
		if (pick == 0) begin
			c = '1;
			return c;
		end
		if (pick == 1)
			return c;
		case ($urandom_range(5))
		0: c.target = 16'd0;
		1: c.target = 16'd1;
		2: c.target = MAXV;
		3: c.target = 16'hfffe;
		4: c.target = 16'($urandom_range(2, 64));
		default: c.target = 16'($urandom);
		endcase
		c.sync_en = 1'($urandom_range(1));
		c.sync_mode = 2'($urandom_range(3));
		c.rst_tgt = 1'($urandom_range(1));
		c.irq_tgt = 1'($urandom_range(1));
		c.irq_max = 1'($urandom_range(1));
		c.irq_repeat = 1'($urandom_range(1));
		c.irq_toggle = 1'($urandom_range(1));
		return c;
	endfunction

	task automatic test_counting();
		chan_cfg_t c;
		c = '0;
		c.target = 16'h0010;
		c.rst_tgt = 1'b1;
		c.irq_tgt = 1'b1;
		c.irq_max = 1'b1;
		apply_settings(c);
		send_counter_word(KIND_TICK, 16'd0, 1'b0, 16'd0);
		send_counter_word(KIND_TICK, 16'd5, 1'b0, 16'd0);
		send_counter_word(KIND_TICK, 16'h000b, 1'b0, 16'd0);
		send_counter_word(KIND_READ, 16'd0, 1'b0, 16'd0);
		send_counter_word(KIND_TICK, MAXV, 1'b0, 16'd0);
		send_counter_word(KIND_WRITE, 16'd0, 1'b0, 16'hfff0);
		send_counter_word(KIND_TICK, 16'h000f, 1'b0, 16'd0);
		send_counter_word(KIND_WRITE, 16'd0, 1'b0, MAXV);
		send_counter_word(KIND_TICK, MAXV, 1'b0, 16'd0);
		for (int k = 1; k <= 3; k++)
			send_counter_word(3'(KIND_APPLY + k), MAXV, 1'b1, MAXV);
		send_counter_word(KIND_READ, 16'd0, 1'b0, 16'd0);
	endtask

	task automatic test_sync();
		chan_cfg_t c;
		c = '0;
		c.sync_en = 1'b1;
		c.sync_mode = SYNC_MODE0;
		apply_settings(c);
		send_counter_word(KIND_APPLY, 16'd0, 1'b0, 16'd0);
		send_counter_word(KIND_TICK, 16'd0, 1'b0, 16'd0);
		send_counter_word(KIND_BLANK, 16'd0, 1'b1, 16'd0);
		send_counter_word(KIND_TICK, 16'd3, 1'b0, 16'd0);
		send_counter_word(KIND_BLANK, 16'd0, 1'b1, 16'd0);
		send_counter_word(KIND_BLANK, 16'd0, 1'b0, 16'd0);
		c.sync_mode = SYNC_MODE3;
		apply_settings(c);
		send_counter_word(KIND_APPLY, 16'd0, 1'b0, 16'd0);
		send_counter_word(KIND_BLANK, 16'd0, 1'b1, 16'd0);
		send_counter_word(KIND_TICK, 16'd2, 1'b0, 16'd0);
		c.sync_mode = SYNC_MODE2;
		apply_settings(c);
		send_counter_word(KIND_APPLY, 16'd0, 1'b0, 16'd0);
		send_counter_word(KIND_BLANK, 16'd0, 1'b0, 16'd0);
		send_counter_word(KIND_BLANK, 16'd0, 1'b1, 16'd0);
	endtask

	task automatic test_irq_toggle();
		chan_cfg_t c;
		c = '0;
		c.target = 16'd2;
		c.rst_tgt = 1'b1;
		c.irq_tgt = 1'b1;
		c.irq_repeat = 1'b1;
		c.irq_toggle = 1'b1;
		apply_settings(c);
		send_counter_word(KIND_APPLY, 16'd0, 1'b0, 16'd0);
		repeat (3) send_counter_word(KIND_TICK, 16'd2, 1'b0, 16'd0);
	endtask

	task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n);
		int        sent;
		int        burst;
		int        pick;
		int        kind_roll;
		logic [2:0]  md;
		logic [15:0] tk;
		logic [15:0] nc;
		sent = 0;
		pick = 0;
		wait_idle();
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (sent < n) begin
			apply_settings(random_settings(pick));
			pick++;
			burst = $urandom_range(30, 70);
			for (int i = 0; i < burst && sent < n; i++) begin
				kind_roll = $urandom_range(99);
				if (kind_roll < 45)
					md = KIND_TICK;
				else if (kind_roll < 65)
					md = KIND_BLANK;
				else if (kind_roll < 77)
					md = KIND_READ;
				else if (kind_roll < 85)
					md = KIND_WRITE;
				else if (kind_roll < 94)
					md = KIND_APPLY;
				else
					md = 3'(KIND_APPLY + $urandom_range(1, 3));
				case ($urandom_range(3))
				0: tk = 16'($urandom);
				1: tk = 16'($urandom_range(0, 15));
				2: tk = chan_cfg.target - chan_counter + 16'($urandom_range(0, 2));
				default: tk = MAXV - chan_counter + 16'($urandom_range(0, 1));
				endcase
				case ($urandom_range(2))
				0: nc = 16'($urandom);
				1: nc = chan_cfg.target - 16'($urandom_range(0, 1));
				default: nc = MAXV - 16'($urandom_range(0, 1));
				endcase
				send_counter_word(md, tk, 1'($urandom_range(1)), nc);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_counting();
		test_sync();
		test_irq_toggle();
		test_random_phase(22, 73, 520);
		test_random_phase(73, 22, 520);
		test_random_phase(0, 0, 520);
		in_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
hw/rtl/rct_pkg.sv
hw/rtl/rct_mod_unit.sv
hw/rtl/root_counter_timer_channel_core.sv
hw/rtl/rct_checker.sv
test/tb_root_counter_timer_channel_core.sv
